// ----- design/cafb_pkg.sv -----
// ----------------------------------------------------------------------------
// cafb_pkg: shared types and constants for the CRC_A frame builder
// Job record passed from the front to the back, byte kinds and the CRC step.
// ----------------------------------------------------------------------------
package cafb_pkg;

    localparam logic [15:0] CRC_A_INIT       = 16'h6363;
    localparam logic [7:0]  FRAME_HEADER     = 8'h55;
    localparam logic [7:0]  LEN_COMPLEMENT   = 8'hFF;
    localparam int          CAFB_QUEUE_DEPTH = 4;

    // byte kinds on the result channel
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_CRC     = 2'd2;

    // one queued job: a frame start or a single payload byte
    typedef struct packed {
        logic       is_start;   // emit header before the payload byte
        logic       last;       // append CRC after the payload byte
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] data;
    } job_t;

    // one byte of CRC_A (ISO 14443-A), reflected form
    function automatic logic [15:0] crc_a_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = b ^ crc[7:0];
        v = v ^ {v[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {v, 8'h00} ^ {5'b00000, v, 3'b000} ^ {12'h000, v[7:4]};
    endfunction

endpackage

// ----- design/cafb_front.sv -----
// ----------------------------------------------------------------------------
// cafb_front: input classifier
// Tracks the open frame, drops stray payload bytes, and queues jobs.
// ----------------------------------------------------------------------------
module cafb_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [23:0]   s_tdata,
    input  logic          s_tuser,
    output logic          push,
    output cafb_pkg::job_t push_job,
    input  logic          queue_full
);
    import cafb_pkg::*;

    logic       frame_open_reg, frame_open_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       accept;
    logic [7:0] in_cmd, in_len, in_data;

    assign in_cmd   = s_tdata[7:0];
    assign in_len   = s_tdata[15:8];
    assign in_data  = s_tdata[23:16];
    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        frame_open_next   = frame_open_reg;
        bytes_left_next   = bytes_left_reg;
        push              = 1'b0;
        push_job.is_start = s_tuser;
        push_job.cmd      = in_cmd;
        push_job.len      = in_len;
        push_job.data     = in_data;
        push_job.last     = 1'b0;
        if (accept) begin
            if (s_tuser) begin
                push            = 1'b1;
                push_job.last   = (in_len == 8'd1);
                frame_open_next = (in_len > 8'd1);
                bytes_left_next = (in_len == 8'd0) ? 8'd0 : in_len - 8'd1;
            end else if (frame_open_reg) begin
                push            = 1'b1;
                push_job.last   = (bytes_left_reg == 8'd1);
                frame_open_next = (bytes_left_reg != 8'd1);
                bytes_left_next = bytes_left_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 8'd0;
        end else begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// ----- design/cafb_queue.sv -----
// ----------------------------------------------------------------------------
// cafb_queue: job queue
// Small FIFO between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module cafb_queue #(
    parameter int DEPTH = cafb_pkg::CAFB_QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cafb_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output cafb_pkg::job_t pop_job,
    output logic           empty
);
    import cafb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/cafb_back.sv -----
// ----------------------------------------------------------------------------
// cafb_back: byte sequencer
// Walks each job through header, payload and CRC phases, one byte a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module cafb_back (
    input  logic           aclk,
    input  logic           aresetn,
    output logic           pop,
    input  cafb_pkg::job_t pop_job,
    input  logic           queue_empty,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [2:0]     m_tuser,
    output logic           m_tlast
);
    import cafb_pkg::*;

    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_CMD  = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_NLEN = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CRCL = 3'd5;
    localparam logic [2:0] PH_CRCH = 3'd6;

    job_t        job_reg;
    logic        busy_reg, busy_next;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [1:0]  out_kind_reg;
    logic        out_end_reg, out_run_last_reg;

    logic        advance, emit, done;
    logic [2:0]  step_phase;
    logic [7:0]  byte_sel;
    logic [1:0]  kind_sel;
    logic [15:0] crc_base;

    assign advance = !out_valid_reg || m_tready;
    assign emit    = busy_reg && advance;
    assign pop     = (!busy_reg || (emit && done)) && !queue_empty;

    always_comb begin
        step_phase = phase_reg;
        done       = 1'b0;
        byte_sel   = FRAME_HEADER;
        kind_sel   = KIND_HEADER;
        unique case (phase_reg)
            PH_HDR: begin
                step_phase = PH_CMD;
            end
            PH_CMD: begin
                byte_sel   = job_reg.cmd;
                step_phase = PH_LEN;
            end
            PH_LEN: begin
                byte_sel   = job_reg.len;
                step_phase = PH_NLEN;
            end
            PH_NLEN: begin
                byte_sel   = LEN_COMPLEMENT - job_reg.len;
                step_phase = (job_reg.len == 8'd0) ? PH_CRCL : PH_DATA;
            end
            PH_DATA: begin
                byte_sel   = job_reg.data;
                kind_sel   = KIND_PAYLOAD;
                step_phase = PH_CRCL;
                done       = !job_reg.last;
            end
            PH_CRCL: begin
                byte_sel   = crc_reg[7:0];
                kind_sel   = KIND_CRC;
                step_phase = PH_CRCH;
            end
            PH_CRCH: begin
                byte_sel = crc_reg[15:8];
                kind_sel = KIND_CRC;
                done     = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    // restart the CRC on the header byte; hold it across the trailer
    assign crc_base = (phase_reg == PH_HDR) ? CRC_A_INIT : crc_reg;

    always_comb begin
        crc_next   = crc_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        if (emit) begin
            if (kind_sel != KIND_CRC) begin
                crc_next = crc_a_step(crc_base, byte_sel);
            end
            phase_next = step_phase;
            if (done) begin
                busy_next = 1'b0;
            end
        end
        if (pop) begin
            busy_next  = 1'b1;
            phase_next = pop_job.is_start ? PH_HDR : PH_DATA;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= pop_job;
        end
        if (emit) begin
            out_byte_reg     <= byte_sel;
            out_kind_reg     <= kind_sel;
            out_end_reg      <= (phase_reg == PH_CRCH);
            out_run_last_reg <= done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_HDR;
            crc_reg       <= CRC_A_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            if (advance) begin
                out_valid_reg <= emit;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_run_last_reg, out_kind_reg};
    assign m_tlast  = out_end_reg;

endmodule

// ----- design/crc_a_frame_builder.sv -----
// ----------------------------------------------------------------------------
// crc_a_frame_builder: streaming frame builder with CRC_A trailer
// Wraps byte requests into frames: header, payload and ISO 14443-A CRC.
// ----------------------------------------------------------------------------
// Usage:
//   Send a start request (s_tuser = 1) with command and length; the block
//   emits 0x55, command, length, 0xFF - length and, for a non-empty frame,
//   the request's data byte as the first payload byte. Each later request
//   (s_tuser = 0) adds one payload byte. After the last payload byte the
//   CRC_A (init 0x6363, over header and payload) follows, low byte first.
//   A zero-length start emits header and CRC at once. Payload requests with
//   no open frame are dropped; a new start abandons an open frame.
// Throughput: while m_tready allows, the sequencer emits one byte per cycle, so
//   payload requests other than the last flow at one per cycle; a start request
//   makes 5 to 7 bytes (5 with more payload to come, 6 for a zero-length frame,
//   7 for a one-byte frame), and the job queue (QUEUE_DEPTH entries) soaks up
//   the burst. Requests pass the job queue, job register and output register.
// Reset: clears the open-frame tracking, empties the queue and the output
//   register; no frame is open afterwards.
// Stall: while m_tready is low the output register holds; the sequencer
//   stops and s_tready drops once the job queue is full.
// ----------------------------------------------------------------------------
module crc_a_frame_builder #(
    parameter int QUEUE_DEPTH = cafb_pkg::CAFB_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] command_code, [15:8] payload_length, [23:16] data_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [1:0] byte_kind, [2] run_last
    output logic        m_tlast    // frame_end
);
    import cafb_pkg::*;

    logic push, pop, queue_full, queue_empty;
    job_t push_job, pop_job;

    // classify requests and track the open frame
    cafb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    // decouple the classifier from the byte sequencer
    cafb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (queue_empty)
    );

    // emit header, payload and CRC bytes
    cafb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop         (pop),
        .pop_job     (pop_job),
        .queue_empty (queue_empty),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for crc_a_frame_builder
// Directed table of frame requests, then random frames with random gaps on
// both channels; every result byte is checked against a CRC_A frame predictor.
// ----------------------------------------------------------------------------
module testbench;
    import cafb_pkg::*;

    localparam int          REQUEST_TARGET  = 370;        // counted requests, drops excluded
    localparam int          CYCLE_LIMIT     = 1_000_000;
    localparam int          DRAIN_CYCLES    = 16;
    localparam int          REPORT_LIMIT    = 10;
    localparam int          LONG_FRAME_SLOT = 4;          // random frame that uses the full length
    localparam logic [15:0] CRC_A_POLY_REFL = 16'h8408;   // x^16 + x^12 + x^5 + 1, bit-reversed

    // one byte on the result channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       frame_end;
        logic       run_last;
    } frame_byte_t;

    // one row of the directed table; typed rows carry their bytes, top byte first
    typedef struct packed {
        bit        start;
        bit [7:0]  cmd;
        bit [7:0]  len;
        bit [7:0]  data;
        bit        typed;
        bit [2:0]  n_lit;
        bit [39:0] lit;
    } table_row_t;

    // clock, reset and block ports; every input is known from time zero
    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [7:0] command_code, [15:8] payload_length, [23:16] data_byte
    logic        s_tuser  = 1'b0; // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] out_byte
    logic [2:0]  m_tuser;         // [1:0] byte_kind, [2] run_last
    logic        m_tlast;

    // predictor state, mirrors the block after reset
    logic [15:0] run_crc   = CRC_A_INIT;
    logic [7:0]  bytes_due = 8'd0;
    bit          in_frame  = 1'b0;

    frame_byte_t step_q[$];       // bytes caused by the request being predicted
    frame_byte_t owed_bytes[$];   // predicted bytes not yet seen on the result channel
    table_row_t  dir_rows[$];

    int cycle_count      = 0;
    int requests_sent    = 0;
    int bytes_dropped    = 0;
    int frames_closed    = 0;
    int frames_abandoned = 0;
    int bytes_checked    = 0;
    int mismatches       = 0;
    int stall_left       = 0;
    int run_left         = 0;

    crc_a_frame_builder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // bit-serial reflected CRC over one byte
    function automatic logic [15:0] crc_a_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_A_POLY_REFL) : (c >> 1);
        return c;
    endfunction

    // queue one header or payload byte and fold it into the running CRC
    function void emit_byte(input logic [7:0] b, input logic [1:0] kind);
        frame_byte_t fb;
        fb.out_byte  = b;
        fb.kind      = kind;
        fb.frame_end = 1'b0;
        fb.run_last  = 1'b0;
        step_q.push_back(fb);
        run_crc = crc_a_next(run_crc, b);
    endfunction

    // append the CRC trailer, low byte first, and close the frame
    function void close_frame();
        frame_byte_t fb;
        fb.out_byte  = run_crc[7:0];
        fb.kind      = KIND_CRC;
        fb.frame_end = 1'b0;
        fb.run_last  = 1'b0;
        step_q.push_back(fb);
        fb.out_byte  = run_crc[15:8];
        fb.frame_end = 1'b1;
        step_q.push_back(fb);
        in_frame  = 1'b0;
        bytes_due = 8'd0;
        frames_closed++;
    endfunction

    // work out every byte that one accepted request causes
    function void predict_request(input bit start, input logic [7:0] cmd, input logic [7:0] len,
                                  input logic [7:0] data);
        frame_byte_t fb;
        step_q.delete();
        if (start) begin
            // a new start drops any open frame without its CRC
            if (in_frame)
                frames_abandoned++;
            run_crc   = CRC_A_INIT;
            in_frame  = 1'b0;
            bytes_due = 8'd0;
            emit_byte(FRAME_HEADER, KIND_HEADER);
            emit_byte(cmd, KIND_HEADER);
            emit_byte(len, KIND_HEADER);
            emit_byte(LEN_COMPLEMENT - len, KIND_HEADER);
            if (len == 8'd0) begin
                close_frame();
            end else begin
                emit_byte(data, KIND_PAYLOAD);
                bytes_due = len - 8'd1;
                in_frame  = 1'b1;
                if (bytes_due == 8'd0)
                    close_frame();
            end
        end else if (in_frame) begin
            emit_byte(data, KIND_PAYLOAD);
            bytes_due = bytes_due - 8'd1;
            if (bytes_due == 8'd0)
                close_frame();
        end else begin
            bytes_dropped++;
        end
        // flag the last byte of this request
        if (step_q.size() > 0) begin
            fb = step_q.pop_back();
            fb.run_last = 1'b1;
            step_q.push_back(fb);
        end
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function void add_row(input bit start, input bit [7:0] cmd, input bit [7:0] len,
                          input bit [7:0] data, input bit typed, input bit [2:0] n_lit,
                          input bit [39:0] lit);
        table_row_t r;
        r.start = start;
        r.cmd   = cmd;
        r.len   = len;
        r.data  = data;
        r.typed = typed;
        r.n_lit = n_lit;
        r.lit   = lit;
        dir_rows.push_back(r);
    endfunction

    // present one request, hold it until taken, then record what it owes
    task automatic send_request(input bit start, input bit [7:0] cmd, input bit [7:0] len,
                                input bit [7:0] data, input bit no_gap, input bit typed,
                                input int n_lit, input bit [39:0] lit);
        int          gap;
        frame_byte_t fb;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {data, len, cmd};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_request(start, cmd, len, data);
        // typed rows replace the prediction with bytes read straight off the request
        if (typed) begin
            step_q.delete();
            for (int i = 0; i < n_lit; i++) begin
                fb.out_byte  = lit[39 - 8 * i -: 8];
                fb.kind      = (start && i < 4) ? KIND_HEADER : KIND_PAYLOAD;
                fb.frame_end = 1'b0;
                fb.run_last  = (i == n_lit - 1);
                step_q.push_back(fb);
            end
        end
        while (step_q.size() > 0)
            owed_bytes.push_back(step_q.pop_front());
        requests_sent++;
    endtask

    // hold the sender off until every owed byte has come out
    task automatic wait_for_owed();
        s_tvalid <= 1'b0;
        while (owed_bytes.size() != 0)
            @(posedge aclk);
    endtask

    // result side: random stalls, short runs and long stretches of steady ready
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (run_left > 0) begin
            m_tready <= 1'b1;
            run_left--;
        end else begin
            m_tready  <= 1'b1;
            run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 6);
            stall_left = pick_gap();
        end
    end

    // check each byte taken on the result channel against the oldest owed byte
    always @(posedge aclk) begin
        frame_byte_t seen;
        frame_byte_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            seen.out_byte  = m_tdata;
            seen.kind      = m_tuser[1:0];
            seen.run_last  = m_tuser[2];
            seen.frame_end = m_tlast;
            if (owed_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: byte %02h kind %0d end %0b last %0b",
                             seen.out_byte, seen.kind, seen.frame_end, seen.run_last);
            end else begin
                want = owed_bytes.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d: want %02h/%0d/%0b/%0b got %02h/%0d/%0b/%0b",
                                 bytes_checked, want.out_byte, want.kind, want.frame_end,
                                 want.run_last, seen.out_byte, seen.kind, seen.frame_end,
                                 seen.run_last);
                end
                bytes_checked++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL crc_a_frame_builder");
            $finish;
        end
    end

    initial begin
        int  frame_no;
        int  len;
        int  count;
        int  r;
        bit  calm;
        bit  abandon;

        // directed table: start, cmd, len, data, typed, byte count, bytes top first
        add_row(1'b0, 8'h00, 8'h00, 8'hFF, 1'b1, 3'd0, 40'h0);            // payload with no frame: drop
        add_row(1'b1, 8'h00, 8'h00, 8'hA5, 1'b0, 3'd0, 40'h0);            // zero length, data unused
        add_row(1'b1, 8'hFF, 8'h00, 8'h00, 1'b0, 3'd0, 40'h0);            // zero length, command all ones
        add_row(1'b1, 8'hFF, 8'h01, 8'hFF, 1'b0, 3'd0, 40'h0);            // one-byte frame
        add_row(1'b1, 8'h00, 8'h01, 8'h00, 1'b0, 3'd0, 40'h0);            // one-byte frame, all zeros
        add_row(1'b1, 8'h3C, 8'h03, 8'h00, 1'b1, 3'd5, 40'h55_3C_03_FC_00);
        add_row(1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'd1, 40'hFF_00_00_00_00);
        add_row(1'b0, 8'h12, 8'h34, 8'h5A, 1'b0, 3'd0, 40'h0);            // closes the frame
        add_row(1'b0, 8'h00, 8'h00, 8'h77, 1'b1, 3'd0, 40'h0);            // drop after close
        add_row(1'b1, 8'hA5, 8'h02, 8'h12, 1'b1, 3'd5, 40'h55_A5_02_FD_12);
        add_row(1'b1, 8'h81, 8'hFF, 8'h80, 1'b1, 3'd5, 40'h55_81_FF_00_80); // abandons open frame
        add_row(1'b0, 8'h00, 8'h00, 8'h01, 1'b1, 3'd1, 40'h01_00_00_00_00);
        add_row(1'b1, 8'h00, 8'h80, 8'h7F, 1'b1, 3'd5, 40'h55_00_80_7F_7F); // abandons again
        add_row(1'b1, 8'h42, 8'h00, 8'h00, 1'b0, 3'd0, 40'h0);            // zero length over open frame
        add_row(1'b1, 8'h10, 8'h02, 8'hAA, 1'b1, 3'd5, 40'h55_10_02_FD_AA);
        add_row(1'b0, 8'h00, 8'h00, 8'h55, 1'b0, 3'd0, 40'h0);
        add_row(1'b1, 8'hC3, 8'h01, 8'h3C, 1'b0, 3'd0, 40'h0);
        add_row(1'b0, 8'hFF, 8'hFF, 8'h00, 1'b1, 3'd0, 40'h0);            // drop
        add_row(1'b1, 8'h7E, 8'h02, 8'h81, 1'b1, 3'd5, 40'h55_7E_02_FD_81);
        add_row(1'b0, 8'h00, 8'h00, 8'hE7, 1'b0, 3'd0, 40'h0);

        // reset once
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_request(dir_rows[i].start, dir_rows[i].cmd, dir_rows[i].len, dir_rows[i].data,
                         1'b0, dir_rows[i].typed, int'(dir_rows[i].n_lit), dir_rows[i].lit);

        // let the directed traffic drain completely before random frames
        wait_for_owed();

        // random frames: mostly well formed, some cut short, strays between frames
        frame_no = 0;
        while (requests_sent - bytes_dropped < REQUEST_TARGET) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 4)
                wait_for_owed();
            if (!in_frame && $urandom_range(0, 99) < 10)
                repeat ($urandom_range(1, 3))
                    send_request(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), calm,
                                 1'b0, 0, 40'h0);
            abandon = ($urandom_range(0, 9) == 0);
            if (frame_no == LONG_FRAME_SLOT) begin
                len     = 255;
                abandon = 1'b0;
            end else if (abandon) begin
                len = $urandom_range(2, 255);
            end else begin
                r   = $urandom_range(0, 99);
                len = (r < 30) ? $urandom_range(0, 2) :
                      (r < 90) ? $urandom_range(3, 12) : $urandom_range(13, 40);
            end
            // requests in this frame, start included
            if (abandon)
                count = $urandom_range(1, (len - 1 < 8) ? len - 1 : 8);
            else
                count = (len == 0) ? 1 : len;
            send_request(1'b1, 8'($urandom), 8'(len), 8'($urandom), calm, 1'b0, 0, 40'h0);
            repeat (count - 1)
                send_request(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), calm,
                             1'b0, 0, 40'h0);
            frame_no++;
        end

        // drain, then keep the clock running so that any extra byte would show
        wait_for_owed();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests in %0d random frames: %0d closed, %0d abandoned",
                 requests_sent, frame_no, frames_closed, frames_abandoned);
        $display("dropped %0d strays, checked %0d result bytes, %0d mismatches",
                 bytes_dropped, bytes_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS crc_a_frame_builder");
        end else begin
            $display("FAIL crc_a_frame_builder");
        end
        $finish;
    end

endmodule
